@@ sv/led_flash_pattern_sequencer_assert.svh @@
// assertion macros for the led flash pattern sequencer
`ifndef LED_FLASH_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_FLASH_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LFPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfps assertion failed");

// next-cycle implication, checked out of reset
`define LFPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfps assertion failed");

`endif

@@ sv/lfps_pkg.sv @@
// types, codes and constants of the led flash pattern sequencer
`default_nettype none

package lfps_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_ABORT = 2'd2
  } func_e;

  // step phase within a group
  typedef enum logic [1:0] {
    PH_LIT  = 2'd0,
    PH_DARK = 2'd1,
    PH_WAIT = 2'd2
  } phase_e;

  // configuration register indexes
  localparam logic [0:0] CFG_LOOP_UNIT  = 1'b0;
  localparam logic [0:0] CFG_OUTER_UNIT = 1'b1;

  localparam int unsigned UnitW = 10;
  localparam int unsigned CdW   = 18;

  localparam logic [UnitW-1:0] UNIT_RESET   = 10'd100;
  localparam logic [7:0]       COLOR_OFF    = 8'hFF;
  localparam logic [3:0]       MODE_PATTERN = 4'd1;
  localparam logic [1:0]       LAST_GROUP   = 2'd2;

  // packed group word
  typedef struct packed {
    logic [7:0] color;
    logic [3:0] dark_units;
    logic [3:0] flash_extra;
    logic [7:0] gap_units;
  } grp_word_t;

  // input beat
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  header_byte;
    logic [23:0] group1_word;
    logic [23:0] group2_word;
    logic [23:0] group3_word;
    logic [7:0]  repeat_count;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic       led_on;
    logic [7:0] led_color;
    logic       busy_res;
    logic       start_accepted;
    logic       sequence_done;
  } out_beat_t;

  // unit lengths handed from the register file to the core
  typedef struct packed {
    logic [UnitW-1:0] loop_unit;
    logic [UnitW-1:0] outer_unit;
  } unit_cfg_t;

endpackage

`default_nettype wire

@@ sv/lfps_chan_if.sv @@
// valid/ready channel carrying one beat of a given type
`default_nettype none

interface lfps_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/led_flash_pattern_sequencer.sv @@
// A result beat is valid in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle unless a result waits; the step logic runs in one pass
// between the pattern state registers and the result register.
// Input ready follows the result register: it drops only while a result waits.
// Reset (asynchronous, active low): idle, LED off at colour 255, units 100.
`default_nettype none

module led_flash_pattern_sequencer
  import lfps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_idx_i,
  input  wire logic [UnitW-1:0] cfg_wdata_i,
  lfps_chan_if.sink             in_i,
  lfps_chan_if.source           out_o
);

  `include "led_flash_pattern_sequencer_assert.svh"

  unit_cfg_t units;
  out_beat_t res;
  out_beat_t out_data;
  in_beat_t  in_data;
  logic      free;
  logic      take;
  logic      out_valid;

  assign in_data  = in_i.data;
  assign in_i.ready = free;
  assign take     = in_i.valid && free;

  // configuration registers
  lfps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .units_o     (units)
  );

  // pattern state and step
  lfps_seq_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .beat_i  (in_data),
    .units_i (units),
    .res_o   (res)
  );

  // result register
  lfps_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .out_ready_i (out_o.ready),
    .free_o      (free),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  // every accepted beat leaves a result behind it
  `LFPS_ASSERT_NEXT(a_result_follows, take, out_valid)
  // an accepted start leaves the sequence running
  `LFPS_ASSERT_SAME(a_start_busy, out_valid && out_data.start_accepted, out_data.busy_res)
  // a normal end leaves the LED dark and the block idle
  `LFPS_ASSERT_SAME(a_done_idle, out_valid && out_data.sequence_done,
                    !out_data.busy_res && !out_data.led_on)
  // the LED is lit only during a sequence
  `LFPS_ASSERT_SAME(a_lit_busy, out_valid && out_data.led_on, out_data.busy_res)

endmodule

`default_nettype wire

@@ sv/lfps_cfg_regs.sv @@
// configuration register file with the two delay unit lengths
`default_nettype none

module lfps_cfg_regs
  import lfps_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_idx_i,
  input  wire logic [UnitW-1:0] cfg_wdata_i,
  output unit_cfg_t             units_o
);

  logic [UnitW-1:0] loop_unit_q;
  logic [UnitW-1:0] outer_unit_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_unit_q  <= UNIT_RESET;
      outer_unit_q <= UNIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOOP_UNIT:  loop_unit_q  <= cfg_wdata_i;
        CFG_OUTER_UNIT: outer_unit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign units_o.loop_unit  = loop_unit_q;
  assign units_o.outer_unit = outer_unit_q;

endmodule

`default_nettype wire

@@ sv/lfps_seq_core.sv @@
// pattern state and the single-pass step logic for one beat
`default_nettype none

module lfps_seq_core
  import lfps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      take_i,
  input  wire in_beat_t  beat_i,
  input  wire unit_cfg_t units_i,
  output out_beat_t      res_o
);

  logic             running_q, running_d;
  logic [1:0]       group_idx_q, group_idx_d;
  phase_e           phase_q, phase_d;
  logic [3:0]       flash_cnt_q, flash_cnt_d;
  logic [7:0]       repeats_q, repeats_d;
  logic [3:0]       flash_len_q, flash_len_d;
  grp_word_t        grp_q [3];
  grp_word_t        grp_d [3];
  logic [CdW-1:0]   cd_q, cd_d;
  logic             lamp_on_q, lamp_on_d;
  logic [7:0]       lamp_color_q, lamp_color_d;
  logic             accepted;
  logic             done;

  grp_word_t        cur_grp;
  logic [13:0]      inner_prod;
  logic [CdW-1:0]   after_prod;

  // current group word
  always_comb begin
    case (group_idx_q)
      2'd1:    cur_grp = grp_q[1];
      2'd2:    cur_grp = grp_q[2];
      default: cur_grp = grp_q[0];
    endcase
  end

  // delay lengths in ticks
  assign inner_prod = 14'(cur_grp.dark_units) * 14'(units_i.loop_unit);
  assign after_prod = CdW'(cur_grp.gap_units) * CdW'(units_i.outer_unit);

  // next state
  always_comb begin
    running_d    = running_q;
    group_idx_d  = group_idx_q;
    phase_d      = phase_q;
    flash_cnt_d  = flash_cnt_q;
    repeats_d    = repeats_q;
    flash_len_d  = flash_len_q;
    grp_d        = grp_q;
    cd_d         = cd_q;
    lamp_on_d    = lamp_on_q;
    lamp_color_d = lamp_color_q;
    accepted     = 1'b0;
    done         = 1'b0;
    case (beat_i.func)
      FUNC_TICK: begin
        if (running_q) begin
          if (cd_q > CdW'(1)) begin
            cd_d = cd_q - CdW'(1);
          end else if (group_idx_q > LAST_GROUP) begin
            running_d = 1'b0;
            cd_d      = '0;
          end else begin
            case (phase_q)
              PH_LIT: begin
                lamp_on_d    = 1'b1;
                lamp_color_d = cur_grp.color;
                phase_d      = PH_DARK;
                cd_d         = CdW'(flash_len_q);
              end
              PH_DARK: begin
                lamp_on_d    = 1'b0;
                lamp_color_d = COLOR_OFF;
                if (flash_cnt_q < cur_grp.flash_extra) begin
                  flash_cnt_d = flash_cnt_q + 4'd1;
                  phase_d     = PH_LIT;
                end else begin
                  flash_cnt_d = '0;
                  phase_d     = PH_WAIT;
                end
                cd_d = CdW'(inner_prod);
              end
              PH_WAIT: begin
                if (group_idx_q < LAST_GROUP) begin
                  group_idx_d = group_idx_q + 2'd1;
                  phase_d     = PH_LIT;
                  cd_d        = after_prod;
                end else if (repeats_q != 8'd0) begin
                  repeats_d   = repeats_q - 8'd1;
                  flash_cnt_d = '0;
                  group_idx_d = '0;
                  phase_d     = PH_LIT;
                  cd_d        = after_prod;
                end else begin
                  running_d = 1'b0;
                  cd_d      = '0;
                  done      = 1'b1;
                end
              end
              default: begin
                running_d = 1'b0;
                cd_d      = '0;
              end
            endcase
          end
        end
      end
      FUNC_START: begin
        if (!running_q && beat_i.header_byte[3:0] == MODE_PATTERN) begin
          flash_len_d = beat_i.header_byte[7:4];
          grp_d[0]    = beat_i.group1_word;
          grp_d[1]    = beat_i.group2_word;
          grp_d[2]    = beat_i.group3_word;
          repeats_d   = beat_i.repeat_count;
          group_idx_d = '0;
          phase_d     = PH_LIT;
          flash_cnt_d = '0;
          cd_d        = CdW'(1);
          running_d   = 1'b1;
          accepted    = 1'b1;
        end
      end
      FUNC_ABORT: begin
        lamp_on_d    = 1'b0;
        lamp_color_d = COLOR_OFF;
        running_d    = 1'b0;
        cd_d         = '0;
      end
      default: ;
    endcase
  end

  // result of this beat
  always_comb begin
    res_o.led_on         = lamp_on_d;
    res_o.led_color      = lamp_color_d;
    res_o.busy_res       = running_d;
    res_o.start_accepted = accepted;
    res_o.sequence_done  = done;
  end

  // state registers, updated on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      group_idx_q  <= '0;
      phase_q      <= PH_LIT;
      flash_cnt_q  <= '0;
      repeats_q    <= '0;
      flash_len_q  <= '0;
      grp_q[0]     <= '0;
      grp_q[1]     <= '0;
      grp_q[2]     <= '0;
      cd_q         <= '0;
      lamp_on_q    <= 1'b0;
      lamp_color_q <= COLOR_OFF;
    end else if (take_i) begin
      running_q    <= running_d;
      group_idx_q  <= group_idx_d;
      phase_q      <= phase_d;
      flash_cnt_q  <= flash_cnt_d;
      repeats_q    <= repeats_d;
      flash_len_q  <= flash_len_d;
      grp_q        <= grp_d;
      cd_q         <= cd_d;
      lamp_on_q    <= lamp_on_d;
      lamp_color_q <= lamp_color_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/lfps_out_stage.sv @@
// result register between the step logic and the output channel
`default_nettype none

module lfps_out_stage
  import lfps_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire out_beat_t res_i,
  input  wire logic      out_ready_i,
  output wire logic      free_o,
  output wire logic      out_valid_o,
  output out_beat_t      out_data_o
);

  logic      valid_q, valid_d;
  out_beat_t data_q;

  // the register can take a beat when empty or being drained
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
